// ----- src/lpl_pkg.sv -----
// Package for the lookahead peak limiter: constants, register indexes, FSM state type.
// No dependencies.
`default_nettype none
package lpl_pkg;
  localparam int LOOKAHEAD_DEF = 64;
  localparam int CHANNELS_DEF  = 2;
  localparam logic [17:0] UNITY = 18'd131072;
  localparam logic [23:0] ONE_Q20 = 24'd1048576;
  localparam logic [1:0] REG_CEILING = 2'd0;
  localparam logic [1:0] REG_RELEASE = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_REL, S_POPRD, S_POPCHK, S_PUSH, S_AGERD, S_AGECHK,
    S_MINRD, S_AVG, S_DLY, S_SCALE, S_OUT, S_CLEAR
  } state_t;
endpackage
`default_nettype wire

// ----- src/lpl_ram.sv -----
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module lpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- src/lookahead_peak_limiter_core.sv -----
// Lookahead peak limiter core; uses lpl_pkg and lpl_ram.
// Sequence: when an input beat's peak exceeds the ceiling, a 17-step restoring divider
//   runs, else it is skipped; each deque entry dropped at either end adds a read and a
//   check state. One frame at a time: the next beat is taken no earlier than the cycle
//   in which the result appears, and while that result is unaccepted only with out_tready.
// Reset: synchronous active low; afterwards a clearing pass fills the delay,
//   deque and boxcar memories before in_tready rises.
`default_nettype none
module lookahead_peak_limiter_core #(
  parameter int LOOKAHEAD = lpl_pkg::LOOKAHEAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // sample_left[23:0], sample_right[47:24]
  input  wire logic        in_tuser,   // apply
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // out_left, out_right, gain_now[65:48], zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [20:0] cfg_data
);
  localparam int DQ = LOOKAHEAD + 1;
  localparam int DW = $clog2(DQ);
  localparam int AW = (LOOKAHEAD > 1) ? $clog2(LOOKAHEAD) : 1;
  localparam int SW = 18 + $clog2(LOOKAHEAD + 1);
  localparam int CW = $clog2(DQ + 1);
  localparam int SH = $clog2(LOOKAHEAD);
  localparam bit POW2 = (1 << SH) == LOOKAHEAD;
  // reciprocal of LOOKAHEAD, exact for any SW-bit sum
  localparam int RK = SW + SH;
  localparam longint unsigned RM = ((64'd1 << RK) + 64'(LOOKAHEAD) - 64'd1)
                                   / 64'(LOOKAHEAD);
  localparam int MW = 2 * SW + 2;

  // configuration
  logic [20:0] ceil_r; logic [15:0] rc_r; logic [1:0] chn_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r <= 21'd1027604; rc_r <= 16'd65470; chn_r <= 2'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        lpl_pkg::REG_CEILING:  ceil_r <= cfg_data;
        lpl_pkg::REG_RELEASE:  rc_r <= cfg_data[15:0];
        lpl_pkg::REG_CHANNELS: chn_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  lpl_pkg::state_t st_r, st_nxt;
  logic [23:0] sl_r, sr_r; logic ap_r, stereo_r;
  logic [23:0] peak_r;
  logic [37:0] rem_r; logic [17:0] q_r; logic [5:0] cnt_r; logic div_r;
  logic [17:0] rg_r;
  logic [DW-1:0] head_r; logic [CW-1:0] tail_r;
  logic [31:0] fc_r;
  logic [SW-1:0] sum_r; logic [AW-1:0] apos_r, dpos_r;
  logic [17:0] gain_r; logic [AW:0] clr_r;
  logic [23:0] ol_c, or_c; logic [71:0] od_r; logic ov_r;
  logic [49:0] ml_r, mr_r;
  logic [23:0] dl_r, dr_r;

  // deque memory: value and stamp together
  logic dq_we; logic [DW-1:0] dq_wa, dq_ra; logic [49:0] dq_wd, dq_rd;
  lpl_ram #(.WIDTH(50), .DEPTH(DQ)) u_dq (.clk, .we(dq_we), .waddr(dq_wa),
    .wdata(dq_wd), .raddr(dq_ra), .rdata(dq_rd));
  // boxcar ring
  logic av_we; logic [AW-1:0] av_a; logic [17:0] av_wd, av_rd;
  lpl_ram #(.WIDTH(18), .DEPTH(LOOKAHEAD)) u_av (.clk, .we(av_we), .waddr(av_a),
    .wdata(av_wd), .raddr(av_a), .rdata(av_rd));
  // delay line, both channels
  logic dl_we; logic [AW-1:0] dl_a; logic [47:0] dl_wd, dl_rd;
  lpl_ram #(.WIDTH(48), .DEPTH(LOOKAHEAD)) u_dl (.clk, .we(dl_we), .waddr(dl_a),
    .wdata(dl_wd), .raddr(dl_a), .rdata(dl_rd));

  function automatic logic [DW-1:0] wrap(input logic [DW:0] v);
    return (v >= (DW+1)'(DQ)) ? DW'(v - (DW+1)'(DQ)) : DW'(v);
  endfunction

  function automatic logic [23:0] mag(input logic [23:0] s);
    return s[23] ? 24'(-s) : s;
  endfunction

  function automatic logic [23:0] fin(input logic [23:0] s, input logic [49:0] m);
    logic [32:0] r;
    r = 33'((m + 50'd65536) >> 17);
    if (r > 33'(lpl_pkg::ONE_Q20)) r = 33'(lpl_pkg::ONE_Q20);
    return s[23] ? 24'(-r) : r[23:0];
  endfunction

  logic [DW-1:0] back_idx;
  assign back_idx = wrap((DW+1)'(head_r) + (DW+1)'(tail_r) - (DW+1)'(1));
  logic [37:0] trial;
  assign trial = {rem_r[36:0], 1'b0} - {14'd0, peak_r};
  logic [17:0] wmin;
  assign wmin = dq_rd[49:32];
  logic [SW-1:0] nsum;
  assign nsum = sum_r + SW'(wmin) - SW'(av_rd);
  logic [17:0] avg;
  assign avg = POW2 ? 18'(nsum >> SH) : 18'((MW'(nsum) * MW'(RM)) >> RK);

  // output samples: scaled and clamped when applied, right fixed at zero in mono
  assign ol_c = ap_r ? fin(dl_r, ml_r) : dl_r;
  assign or_c = stereo_r ? (ap_r ? fin(dr_r, mr_r) : dr_r) : 24'd0;

  always_comb begin
    st_nxt = st_r;
    dq_we = 1'b0; dq_wa = '0; dq_wd = '0; dq_ra = head_r;
    av_we = 1'b0; av_wd = wmin; av_a = apos_r;
    dl_we = 1'b0; dl_wd = {sr_r, sl_r}; dl_a = dpos_r;
    in_tready = 1'b0;
    case (st_r)
      lpl_pkg::S_CLEAR: begin
        dq_we = 1'b1; dq_wa = DW'(clr_r); dq_wd = {lpl_pkg::UNITY, 32'd0};
        av_we = clr_r < (AW+1)'(LOOKAHEAD); av_a = AW'(clr_r); av_wd = lpl_pkg::UNITY;
        dl_we = av_we; dl_a = AW'(clr_r); dl_wd = '0;
        if (clr_r == (AW+1)'(LOOKAHEAD)) st_nxt = lpl_pkg::S_IDLE;
      end
      lpl_pkg::S_IDLE: begin
        in_tready = !ov_r || out_tready;
        if (in_tvalid && in_tready) st_nxt = lpl_pkg::S_DIV;
      end
      lpl_pkg::S_DIV: if (div_r && cnt_r == 6'd0) st_nxt = lpl_pkg::S_REL;
      lpl_pkg::S_REL: begin dq_ra = back_idx; st_nxt = lpl_pkg::S_POPRD; end
      lpl_pkg::S_POPRD: begin dq_ra = back_idx; st_nxt = lpl_pkg::S_POPCHK; end
      lpl_pkg::S_POPCHK: begin
        dq_ra = back_idx;
        if (tail_r != '0 && wmin >= rg_r) st_nxt = lpl_pkg::S_POPRD;
        else st_nxt = lpl_pkg::S_PUSH;
      end
      lpl_pkg::S_PUSH: begin
        dq_we = 1'b1;
        dq_wa = (tail_r >= CW'(DQ)) ? head_r
              : wrap((DW+1)'(head_r) + (DW+1)'(tail_r));
        dq_wd = {rg_r, fc_r};
        st_nxt = lpl_pkg::S_AGERD;
      end
      lpl_pkg::S_AGERD: st_nxt = lpl_pkg::S_AGECHK;
      lpl_pkg::S_AGECHK: begin
        if (tail_r > CW'(1) && (fc_r - dq_rd[31:0]) >= 32'(LOOKAHEAD))
          st_nxt = lpl_pkg::S_AGERD;
        else st_nxt = lpl_pkg::S_MINRD;
      end
      lpl_pkg::S_MINRD: st_nxt = lpl_pkg::S_AVG;
      lpl_pkg::S_AVG: begin av_we = 1'b1; st_nxt = lpl_pkg::S_DLY; end
      lpl_pkg::S_DLY: begin
        // mono keeps the right-channel history; dl_rd holds this entry already
        dl_we = 1'b1;
        dl_wd = {stereo_r ? sr_r : dl_rd[47:24], sl_r};
        st_nxt = lpl_pkg::S_SCALE;
      end
      lpl_pkg::S_SCALE: st_nxt = lpl_pkg::S_OUT;
      lpl_pkg::S_OUT: st_nxt = lpl_pkg::S_IDLE;
      default: st_nxt = lpl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lpl_pkg::S_CLEAR; clr_r <= '0; ov_r <= 1'b0;
      rg_r <= lpl_pkg::UNITY; head_r <= '0; tail_r <= '0; fc_r <= '0;
      sum_r <= SW'(LOOKAHEAD) * SW'(lpl_pkg::UNITY); apos_r <= '0; dpos_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == lpl_pkg::S_OUT) ov_r <= 1'b1;
      else if (out_tvalid && out_tready) ov_r <= 1'b0;
      case (st_r)
        lpl_pkg::S_CLEAR: clr_r <= clr_r + 1'b1;
        lpl_pkg::S_IDLE: if (in_tvalid && in_tready) begin
          stereo_r <= chn_r[1];
          sl_r <= in_tdata[23:0];
          sr_r <= chn_r[1] ? in_tdata[47:24] : 24'd0;
          ap_r <= in_tuser;
          peak_r <= (chn_r[1] && mag(in_tdata[47:24]) > mag(in_tdata[23:0]))
                  ? mag(in_tdata[47:24]) : mag(in_tdata[23:0]);
          div_r <= 1'b0; cnt_r <= 6'd17;
        end
        lpl_pkg::S_DIV: begin
          if (!div_r) begin
            div_r <= 1'b1;
            if (peak_r <= 24'(ceil_r)) begin
              q_r <= lpl_pkg::UNITY; rem_r <= '0; cnt_r <= '0;
            end else begin
              q_r <= '0; rem_r <= {17'd0, ceil_r};
            end
          end else if (cnt_r != 6'd0) begin
            // restoring division of ceiling*2^17 by peak, one bit a cycle
            cnt_r <= cnt_r - 1'b1;
            if (!trial[37]) begin rem_r <= trial; q_r <= {q_r[16:0], 1'b1}; end
            else begin rem_r <= {rem_r[36:0], 1'b0}; q_r <= {q_r[16:0], 1'b0}; end
          end
        end
        lpl_pkg::S_REL: begin
          if (q_r < rg_r) rg_r <= q_r;
          else rg_r <= rg_r + 18'((({16'd0, q_r - rg_r}) * (34'd65536 - 34'(rc_r))
                       + 34'd65535) >> 16);
        end
        lpl_pkg::S_POPCHK:
          if (tail_r != '0 && wmin >= rg_r) tail_r <= tail_r - 1'b1;
        lpl_pkg::S_PUSH: begin
          if (tail_r >= CW'(DQ)) begin
            head_r <= wrap((DW+1)'(head_r) + (DW+1)'(1)); tail_r <= CW'(DQ);
          end else tail_r <= tail_r + 1'b1;
        end
        lpl_pkg::S_AGECHK:
          if (tail_r > CW'(1) && (fc_r - dq_rd[31:0]) >= 32'(LOOKAHEAD)) begin
            head_r <= wrap((DW+1)'(head_r) + (DW+1)'(1)); tail_r <= tail_r - 1'b1;
          end
        lpl_pkg::S_AVG: begin
          sum_r <= nsum; gain_r <= avg;
          apos_r <= (apos_r == AW'(LOOKAHEAD - 1)) ? '0 : apos_r + 1'b1;
        end
        lpl_pkg::S_DLY: begin
          dpos_r <= (dpos_r == AW'(LOOKAHEAD - 1)) ? '0 : dpos_r + 1'b1;
        end
        lpl_pkg::S_SCALE: begin
          dl_r <= dl_rd[23:0]; dr_r <= dl_rd[47:24];
          ml_r <= 50'(mag(dl_rd[23:0])) * 50'(gain_r);
          mr_r <= 50'(mag(dl_rd[47:24])) * 50'(gain_r);
        end
        lpl_pkg::S_OUT: begin
          od_r <= {6'd0, gain_r, or_c, ol_c};
          fc_r <= fc_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
endmodule
`default_nettype wire

// ----- src/lpl_checker.sv -----
// Port-level checks for lookahead_peak_limiter_core, bound into that module.
// Depends on lookahead_peak_limiter_core ports only.
`default_nettype none
module lpl_checker (
  input wire logic clk, rst_n, in_tvalid, in_tready, out_tvalid, out_tready,
  input wire logic [71:0] out_tdata
);
  a_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:48] <= 18'd131072) else $error("gain above unity");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out dropped");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("second beat taken in flight");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:66] == 6'd0) else $error("pad nonzero");
endmodule
bind lookahead_peak_limiter_core lpl_checker u_chk (.clk, .rst_n, .in_tvalid, .in_tready,
  .out_tvalid, .out_tready, .out_tdata);
`default_nettype wire

// ----- tb/lookahead_peak_limiter_checker.sv -----
// Checker for the lookahead peak limiter: watches config, input and result beats,
// predicts each result frame and compares it field by field. Depends on lpl_pkg.
`default_nettype none
module lookahead_peak_limiter_checker #(
  parameter int LOOKAHEAD = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [20:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DQ = LOOKAHEAD + 1;

  typedef struct packed {
    logic [23:0] left;
    logic [23:0] right;
    logic [17:0] gain;
  } frame_t;

  frame_t expected_frames[$];

  // limiter configuration and state mirror
  logic [20:0] ceil_q;
  logic [15:0] rel_coeff;
  logic [1:0]  chan_cnt;
  logic signed [23:0] dly_mem[2][LOOKAHEAD];
  int unsigned dly_idx, follow_gain, dq_first, dq_count, frame_no, box_idx;
  int unsigned dq_val[DQ];
  int unsigned dq_stamp[DQ];
  int unsigned box_mem[LOOKAHEAD];
  longint unsigned box_sum;

  function automatic logic [23:0] apply_gain(logic signed [23:0] s, int unsigned g);
    longint unsigned m, r;
    m = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    r = (m * g + 65536) >> 17;
    if (r > 1048576) r = 1048576;
    return (s < 0) ? 24'(-longint'(r)) : 24'(r);
  endfunction

  function automatic frame_t limit_frame(logic [47:0] data, logic apply_en);
    logic signed [23:0] smp[2];
    int unsigned n_act, peak, need, lowest, slot, mag;
    longint unsigned diff;
    frame_t f;
    smp[0] = data[23:0];
    smp[1] = data[47:24];
    n_act = (chan_cnt >= 2) ? 2 : 1;
    peak = 0;
    for (int c = 0; c < n_act; c++) begin
      mag = (smp[c] < 0) ? -int'(smp[c]) : int'(smp[c]);
      if (mag > peak) peak = mag;
    end
    need = (peak > ceil_q) ? int'((longint'(ceil_q) * 131072) / peak) : 131072;
    // instant attack, rounded-up one-pole release
    if (need < follow_gain) follow_gain = need;
    else begin
      diff = need - follow_gain;
      follow_gain += int'((diff * (65536 - rel_coeff) + 65535) >> 16);
    end
    // monotonic deque for the sliding minimum
    while (dq_count > 0 && dq_val[(dq_first + dq_count - 1) % DQ] >= follow_gain)
      dq_count--;
    if (dq_count >= DQ) begin
      dq_first = (dq_first + 1) % DQ;
      dq_count = DQ - 1;
    end
    slot = (dq_first + dq_count) % DQ;
    dq_val[slot] = follow_gain;
    dq_stamp[slot] = frame_no;
    dq_count++;
    while (dq_count > 1 && (frame_no - dq_stamp[dq_first]) >= LOOKAHEAD) begin
      dq_first = (dq_first + 1) % DQ;
      dq_count--;
    end
    // boxcar average of the minima
    lowest = dq_val[dq_first];
    box_sum = box_sum + lowest - box_mem[box_idx];
    box_mem[box_idx] = lowest;
    box_idx = (box_idx + 1) % LOOKAHEAD;
    f.gain = 18'(box_sum / LOOKAHEAD);
    f.left = '0;
    f.right = '0;
    for (int c = 0; c < n_act; c++) begin
      logic [23:0] r;
      r = apply_en ? apply_gain(dly_mem[c][dly_idx], f.gain) : dly_mem[c][dly_idx];
      dly_mem[c][dly_idx] = smp[c];
      if (c == 0) f.left = r; else f.right = r;
    end
    dly_idx = (dly_idx + 1) % LOOKAHEAD;
    frame_no++;
    return f;
  endfunction

  assign pending = expected_frames.size();

  always @(posedge clk) begin
    frame_t got, want;
    int errs;
    if (!rst_n) begin
      fail_count <= 0;
      ceil_q = 21'd1027604;
      rel_coeff = 16'd65470;
      chan_cnt = 2'd2;
      for (int i = 0; i < LOOKAHEAD; i++) begin
        dly_mem[0][i] = '0;
        dly_mem[1][i] = '0;
        box_mem[i] = 131072;
      end
      for (int i = 0; i < DQ; i++) begin
        dq_val[i] = 131072;
        dq_stamp[i] = 0;
      end
      dly_idx = 0; follow_gain = 131072; dq_first = 0; dq_count = 0;
      frame_no = 0; box_idx = 0; box_sum = 64'(LOOKAHEAD) * 131072;
      expected_frames.delete();
    end else begin
      errs = 0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lpl_pkg::REG_CEILING:  ceil_q = cfg_data;
          lpl_pkg::REG_RELEASE:  rel_coeff = cfg_data[15:0];
          lpl_pkg::REG_CHANNELS: chan_cnt = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_frames.push_back(limit_frame(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[23:0], out_tdata[47:24], out_tdata[65:48]};
        if (expected_frames.size() == 0) begin
          $error("result beat with nothing expected: %h", out_tdata);
          errs++;
        end else begin
          want = expected_frames.pop_front();
          if (got.left !== want.left) begin
            $error("out_left expected %h actual %h", want.left, got.left);
            errs++;
          end
          if (got.right !== want.right) begin
            $error("out_right expected %h actual %h", want.right, got.right);
            errs++;
          end
          if (got.gain !== want.gain) begin
            $error("gain_now expected %0d actual %0d", want.gain, got.gain);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule
`default_nettype wire

// ----- tb/lookahead_peak_limiter_core_tb.sv -----
// Top of the limiter testbench: clock, reset, config writes, input bursts and
// receiver stalls. Depends on lpl_pkg, the core and lookahead_peak_limiter_checker.
`default_nettype none
module lookahead_peak_limiter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // sample_left, sample_right
  logic        in_tuser = 0;    // apply
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [71:0] out_tdata;       // out_left, out_right, gain_now, zero pad
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [20:0] cfg_data = '0;
  int          fail_count, pending;
  bit          long_hold = 0;

  // register settings per phase, extremes included
  logic [20:0] ceil_set[5] = '{21'd1027604, 21'd0, 21'd1048576, 21'd524288, 21'd2000};
  logic [20:0] rel_set[5] = '{21'd65470, 21'd0, 21'd65535, 21'd60000, 21'd32768};
  logic [20:0] chan_set[5] = '{21'd2, 21'd1, 21'd2, 21'd0, 21'd3};

  always #1 clk = ~clk;

  lookahead_peak_limiter_core uut (.*);
  lookahead_peak_limiter_checker chk (.*);

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 0;
        for (hold = 0; hold < 600; hold++) @(posedge clk);
        long_hold = 0;
      end
      out_tready <= ($urandom_range(0, 99) < 70) || (($urandom >> 3) % 4 == 0);
    end
  end

  // ends the run if something hangs
  initial begin
    #12ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic cfg_write(logic [1:0] idx, logic [20:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_frame(logic [23:0] l, logic [23:0] r, logic ap);
    in_tvalid <= 1; in_tdata <= {r, l}; in_tuser <= ap;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_sample(int loud);
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(0, loud)) *
                          ($urandom_range(0, 1) ? 1 : -1));
    endcase
  endfunction

  initial begin
    int burst;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: field extremes, apply both ways, overload and silence
    send_frame(24'h7FFFFF, 24'h800000, 1);
    send_frame(24'h800000, 24'h7FFFFF, 0);
    send_frame(24'h000000, 24'h000000, 1);
    send_frame(24'hFFFFFF, 24'h000001, 1);
    send_frame(24'h100000, 24'hF00000, 1);
    for (int i = 0; i < 16; i++) send_frame(24'h000100, 24'hFFFF00, i % 2);
    send_frame(24'h555555, 24'hAAAAAA, 1);
    send_frame(24'hAAAAAA, 24'h555555, 1);
    in_tvalid <= 0;
    drain();

    // phases over register settings
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(lpl_pkg::REG_CEILING, ceil_set[ph]);
      cfg_write(lpl_pkg::REG_RELEASE, rel_set[ph]);
      cfg_write(lpl_pkg::REG_CHANNELS, chan_set[ph]);
      for (int n = 0; n < 385; ) begin
        burst = $urandom_range(1, 40);
        for (int b = 0; b < burst && n < 385; b++, n++) begin
          if (ph == 2 && n == 100) long_hold = 1;
          send_frame(pick_sample(($urandom_range(0, 3) == 0) ? 8388607 : 2097152),
                     pick_sample(2097152), ($urandom_range(0, 4) != 0));
        end
        if ($urandom_range(0, 2) != 0) begin
          in_tvalid <= 0;
          repeat ($urandom_range(1, 150)) @(posedge clk);
        end
      end
      in_tvalid <= 0;
      drain();
    end

    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
src/lpl_pkg.sv
src/lpl_ram.sv
src/lookahead_peak_limiter_core.sv
src/lpl_checker.sv
tb/lookahead_peak_limiter_checker.sv
tb/lookahead_peak_limiter_core_tb.sv
